### rtl/core/csv_pkg.sv
package csv_pkg;

	localparam int MAX_DENSITY = 256;
	localparam int DW          = 9;   // density width
	localparam int NSTEP       = 16;  // quotient bits of the divider
	localparam int AW          = 52;  // width of the root-search terms
	localparam int RW          = 25;  // divider remainder width
	localparam int IW          = 19;  // vertex index width
	localparam logic [DW-1:0] DENSITY_RST = DW'(16);
	localparam logic [2:0]    FACE_LAST   = 3'd5;

	typedef logic signed [1:0] sgn_t;

	// base corner, column direction and row direction per face, x/y/z
	localparam sgn_t FACE_BASE [6][3] = '{
		'{ 2'sd1,  2'sd1,  2'sd1}, '{-2'sd1,  2'sd1, -2'sd1}, '{-2'sd1,  2'sd1, -2'sd1},
		'{-2'sd1, -2'sd1,  2'sd1}, '{-2'sd1,  2'sd1,  2'sd1}, '{ 2'sd1,  2'sd1, -2'sd1}
	};
	localparam sgn_t FACE_COLV [6][3] = '{
		'{ 2'sd0, 2'sd0, -2'sd1}, '{ 2'sd0, 2'sd0,  2'sd1}, '{ 2'sd1, 2'sd0, 2'sd0},
		'{ 2'sd1, 2'sd0,  2'sd0}, '{ 2'sd1, 2'sd0,  2'sd0}, '{-2'sd1, 2'sd0, 2'sd0}
	};
	localparam sgn_t FACE_ROWV [6][3] = '{
		'{ 2'sd0, -2'sd1, 2'sd0}, '{ 2'sd0, -2'sd1, 2'sd0}, '{ 2'sd0,  2'sd0, 2'sd1},
		'{ 2'sd0,  2'sd0, -2'sd1}, '{ 2'sd0, -2'sd1, 2'sd0}, '{ 2'sd0, -2'sd1, 2'sd0}
	};

	// item state through the root-search and divider stages
	typedef struct packed {
		logic                   bad;
		logic                   strip_ok;
		logic [2:0]             neg;
		logic [17:0]            s;
		logic [2:0][AW-1:0]     rhs;
		logic [2:0][AW-1:0]     p;     // q*s
		logic [2:0][AW-1:0]     qq;    // q*q*s
		logic [2:0][14:0]       q;
		logic [RW-1:0]          rem;
		logic [15:0]            tq;
		logic [RW-1:0]          rem_v;
		logic [15:0]            tv;
		logic [IW-1:0]          idx;
	} iter_t;

	function automatic logic signed [11:0] sterm(sgn_t s, logic [9:0] v);
		logic signed [11:0] r;
		r = '0;
		if (s == 2'sd1) begin
			r = $signed({2'b00, v});
		end else if (s == -2'sd1) begin
			r = -$signed({2'b00, v});
		end
		return r;
	endfunction

endpackage

### rtl/core/csv_front.sv
module csv_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_vld,
	input  logic [2:0]               face,
	input  logic [7:0]               col,
	input  logic [7:0]               row,
	input  logic [csv_pkg::DW-1:0]   d,
	input  logic [7:0]               m,
	output logic                     out_vld,
	output csv_pkg::iter_t           out_st
);

	logic       v_s1, v_s2, v_s3;
	logic [2:0] face_s1;
	logic [7:0] col_s1, row_s1;

	logic             bad_s2, strip_s2;
	logic [2:0]       neg_s2;
	logic [2:0][7:0]  mag_s2;
	logic [7:0]       col_s2;
	logic [7:0]       row_s2;
	logic [11:0]      fd_s2;
	logic [16:0]      rowd_s2;

	csv_pkg::iter_t st_s3;

	// stage 2 combinational
	logic             bad_c;
	logic [2:0]       fidx;
	logic [2:0]       neg_c;
	logic [2:0][7:0]  mag_c;
	logic signed [11:0] a_c [3];

	always_comb begin
		bad_c = (face_s1 > csv_pkg::FACE_LAST) || ({1'b0, col_s1} >= d) || ({1'b0, row_s1} >= d);
		fidx  = (face_s1 > csv_pkg::FACE_LAST) ? 3'd0 : face_s1;
		for (int k = 0; k < 3; k++) begin
			a_c[k] = csv_pkg::sterm(csv_pkg::FACE_BASE[fidx][k], {2'b00, m})
				+ csv_pkg::sterm(csv_pkg::FACE_COLV[fidx][k], {1'b0, col_s1, 1'b0})
				+ csv_pkg::sterm(csv_pkg::FACE_ROWV[fidx][k], {1'b0, row_s1, 1'b0});
			neg_c[k] = a_c[k][11];
			mag_c[k] = neg_c[k] ? 8'(-a_c[k]) : a_c[k][7:0];
		end
	end

	// stage 3 combinational
	logic [2:0][15:0] sq_c;
	csv_pkg::iter_t   st_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sq_c[k] = {8'b0, mag_s2[k]} * {8'b0, mag_s2[k]};
		end
		st_c          = '0;
		st_c.bad      = bad_s2;
		st_c.strip_ok = strip_s2;
		st_c.neg      = neg_s2;
		st_c.s        = 18'({2'b00, sq_c[0]} + {2'b00, sq_c[1]} + {2'b00, sq_c[2]});
		for (int k = 0; k < 3; k++) begin
			st_c.rhs[k] = csv_pkg::AW'(sq_c[k]) << 30;
		end
		st_c.rem   = csv_pkg::RW'({col_s2, 16'b0}) + csv_pkg::RW'(m);
		st_c.rem_v = csv_pkg::RW'({row_s2, 16'b0}) + csv_pkg::RW'(m);
		st_c.idx   = csv_pkg::IW'(fd_s2) * csv_pkg::IW'(d) + csv_pkg::IW'(rowd_s2)
			+ csv_pkg::IW'(col_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		face_s1  <= face;
		col_s1   <= col;
		row_s1   <= row;
		bad_s2   <= bad_c;
		strip_s2 <= row_s1 < m;
		neg_s2   <= neg_c;
		mag_s2   <= mag_c;
		col_s2   <= col_s1;
		row_s2   <= row_s1;
		fd_s2    <= {9'b0, face_s1} * {3'b0, d};
		rowd_s2  <= {9'b0, row_s1} * {8'b0, d};
		st_s3    <= st_c;
	end

	assign out_vld = v_s3;
	assign out_st  = st_s3;

endmodule

### rtl/core/csv_iter.sv
module csv_iter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  csv_pkg::iter_t      in_st,
	input  logic [7:0]          m,
	output logic                out_vld,
	output csv_pkg::iter_t      out_st
);

	localparam int N = csv_pkg::NSTEP;
	localparam int W = csv_pkg::AW;

	csv_pkg::iter_t cur [N];
	csv_pkg::iter_t nxt [N];
	csv_pkg::iter_t iter_s [N];
	logic [N-1:0]   vld_s;

	for (genvar j = 0; j < N; j++) begin : g_step
		localparam int B = N - 1 - j;
		if (j == 0) begin : g_first
			assign cur[j] = in_st;
		end else begin : g_rest
			assign cur[j] = iter_s[j-1];
		end

		// stage j settles quotient bit B; root search bit B from the second stage on
		always_comb begin
			logic [csv_pkg::RW-1:0] dsh;
			logic [W-1:0] t, kp;
			nxt[j] = cur[j];
			dsh = csv_pkg::RW'({m, 1'b0}) << B;
			if (cur[j].rem >= dsh) begin
				nxt[j].rem   = cur[j].rem - dsh;
				nxt[j].tq[B] = 1'b1;
			end
			if (cur[j].rem_v >= dsh) begin
				nxt[j].rem_v = cur[j].rem_v - dsh;
				nxt[j].tv[B] = 1'b1;
			end
			if (j > 0) begin
				for (int k = 0; k < 3; k++) begin
					// (2q + 2^(B+1) - 1)^2 * s from the running q*s and q*q*s
					kp = (cur[j].p[k] << (B + 1)) - cur[j].p[k];
					t  = (cur[j].qq[k] << 2) + (kp << 2)
						+ (W'(cur[j].s) << (2 * B + 2)) - (W'(cur[j].s) << (B + 2))
						+ W'(cur[j].s);
					if (t <= cur[j].rhs[k]) begin
						nxt[j].q[k][B % 15] = 1'b1;
						nxt[j].qq[k] = cur[j].qq[k] + (cur[j].p[k] << (B + 1))
							+ (W'(cur[j].s) << (2 * B));
						nxt[j].p[k]  = cur[j].p[k] + (W'(cur[j].s) << B);
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			iter_s[j] <= nxt[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[N-2:0], in_vld};
		end
	end

	assign out_vld = vld_s[N-1];
	assign out_st  = iter_s[N-1];

endmodule

### rtl/core/cube_sphere_vertex_generator.sv
// channel   | handshake               | payload
// ----------+-------------------------+---------------------------------------------
// command   | start / busy            | cube_face, grid_col, grid_row
// result    | done (one-cycle strobe) | pos_x/y/z, tex_u/v, vertex_index,
//           |                         | strip_partner, strip_pair_valid, bad_coordinate
// config    | cfg_valid / cfg_ready   | cfg_data (grid_density)
//
// One vertex per clock; busy never rises, cfg_ready is always high.
// From start to done the path runs through three setup stages, sixteen
// stages of the per-bit root search and texture divider, and one output register.
// Reset clears the stage valid bits and loads grid_density with 16.
// The receiver cannot stall, so nothing is ever held back.
module cube_sphere_vertex_generator (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [2:0]             cube_face,
	input  logic [7:0]             grid_col,
	input  logic [7:0]             grid_row,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [csv_pkg::DW-1:0] cfg_data,
	output logic                   done,
	output logic signed [15:0]     pos_x,
	output logic signed [15:0]     pos_y,
	output logic signed [15:0]     pos_z,
	output logic [15:0]            tex_u,
	output logic [15:0]            tex_v,
	output logic [csv_pkg::IW-1:0] vertex_index,
	output logic [csv_pkg::IW-1:0] strip_partner,
	output logic                   strip_pair_valid,
	output logic                   bad_coordinate
);

	logic [csv_pkg::DW-1:0] grid_density_q;
	logic [csv_pkg::DW-1:0] d;
	logic [7:0]             m;

	logic           f_vld, i_vld;
	csv_pkg::iter_t f_st, i_st;

	logic done_q;
	logic [2:0][15:0] pos_q;
	logic [15:0] tex_u_q, tex_v_q;
	logic [csv_pkg::IW-1:0] idx_q, partner_q;
	logic strip_q, bad_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_comb begin
		if (grid_density_q < csv_pkg::DW'(2)) begin
			d = csv_pkg::DW'(2);
		end else if (grid_density_q > csv_pkg::DW'(csv_pkg::MAX_DENSITY)) begin
			d = csv_pkg::DW'(csv_pkg::MAX_DENSITY);
		end else begin
			d = grid_density_q;
		end
		m = 8'(d - csv_pkg::DW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_density_q <= csv_pkg::DENSITY_RST;
		end else if (cfg_valid && cfg_ready) begin
			grid_density_q <= cfg_data;
		end
	end

	csv_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start && !busy),
		.face    (cube_face),
		.col     (grid_col),
		.row     (grid_row),
		.d       (d),
		.m       (m),
		.out_vld (f_vld),
		.out_st  (f_st)
	);

	csv_iter u_iter (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (f_vld),
		.in_st   (f_st),
		.m       (m),
		.out_vld (i_vld),
		.out_st  (i_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= i_vld;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (i_st.bad) begin
				pos_q[k] <= '0;
			end else if (i_st.neg[k]) begin
				pos_q[k] <= 16'(-{1'b0, i_st.q[k]});
			end else begin
				pos_q[k] <= {1'b0, i_st.q[k]};
			end
		end
		tex_u_q   <= i_st.bad ? '0 : i_st.tq;
		tex_v_q   <= i_st.bad ? '0 : i_st.tv;
		idx_q     <= i_st.bad ? '0 : i_st.idx;
		strip_q   <= !i_st.bad && i_st.strip_ok;
		partner_q <= (!i_st.bad && i_st.strip_ok) ? i_st.idx + csv_pkg::IW'(d) : '0;
		bad_q     <= i_st.bad;
	end

	assign done             = done_q;
	assign pos_x            = pos_q[0];
	assign pos_y            = pos_q[1];
	assign pos_z            = pos_q[2];
	assign tex_u            = tex_u_q;
	assign tex_v            = tex_v_q;
	assign vertex_index     = idx_q;
	assign strip_partner    = partner_q;
	assign strip_pair_valid = strip_q;
	assign bad_coordinate   = bad_q;

endmodule

### rtl/core/csv_checker.sv
module csv_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   done,
	input logic signed [15:0]     pos_x,
	input logic signed [15:0]     pos_y,
	input logic signed [15:0]     pos_z,
	input logic [15:0]            tex_u,
	input logic [csv_pkg::IW-1:0] vertex_index,
	input logic [csv_pkg::IW-1:0] strip_partner,
	input logic                   strip_pair_valid,
	input logic                   bad_coordinate
);

	localparam int LAT = 20;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("command without result after fixed latency");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && bad_coordinate |-> pos_x == 0 && pos_y == 0 && pos_z == 0
			&& tex_u == 0 && vertex_index == 0 && !strip_pair_valid)
		else $error("bad coordinate result carries data");

	a_no_partner: assert property (@(posedge clk) disable iff (!arst_n)
		done && !strip_pair_valid |-> strip_partner == 0)
		else $error("strip partner without a pair");

	a_tex_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> tex_u <= 16'd32768)
		else $error("texture u out of range");

endmodule

bind cube_sphere_vertex_generator csv_checker u_csv_checker (.*);

### test/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 20;

	typedef enum logic [2:0] {
		FACE_PX, FACE_NX, FACE_PY, FACE_NY, FACE_PZ, FACE_NZ, FACE_NONE6, FACE_NONE7
	} face_e;

	typedef struct {
		logic [2:0] face;
		logic [7:0] col;
		logic [7:0] row;
	} grid_pt_t;

	typedef struct {
		logic signed [15:0]     px, py, pz;
		logic [15:0]            u, v;
		logic [csv_pkg::IW-1:0] idx, partner;
		logic                   pair_ok, bad;
	} vertex_t;

	// base corner, column step and row step per face, x/y/z
	int corner_tbl [6][3] = '{'{1, 1, 1}, '{-1, 1, -1}, '{-1, 1, -1},
		'{-1, -1, 1}, '{-1, 1, 1}, '{1, 1, -1}};
	int colstep_tbl [6][3] = '{'{0, 0, -1}, '{0, 0, 1}, '{1, 0, 0},
		'{1, 0, 0}, '{1, 0, 0}, '{-1, 0, 0}};
	int rowstep_tbl [6][3] = '{'{0, -1, 0}, '{0, -1, 0}, '{0, 0, 1},
		'{0, 0, -1}, '{0, -1, 0}, '{0, -1, 0}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] cube_face = '0;
	logic [7:0] grid_col = '0;
	logic [7:0] grid_row = '0;
	logic cfg_valid = 1'b0;
	logic [csv_pkg::DW-1:0] cfg_data = '0;
	logic busy, cfg_ready, done;
	logic signed [15:0] pos_x, pos_y, pos_z;
	logic [15:0] tex_u, tex_v;
	logic [csv_pkg::IW-1:0] vertex_index, strip_partner;
	logic strip_pair_valid, bad_coordinate;

	logic [csv_pkg::DW-1:0] density_reg = csv_pkg::DENSITY_RST;
	grid_pt_t point_q[$];
	vertex_t vertex_q[$];
	bit failed = 0;
	bit steady = 0;     // no sender gaps when set
	int burst_left = 0;
	int gap_left = 0;

	cube_sphere_vertex_generator uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int eff_density();
		int d;
		d = density_reg;
		if (d < 2) d = 2;
		if (d > csv_pkg::MAX_DENSITY) d = csv_pkg::MAX_DENSITY;
		return d;
	endfunction

	function automatic void queue_point(grid_pt_t p);
		point_q.insert(point_q.size(), p);
	endfunction

	// bitwise search for round(16384*mag/sqrt(s)), half away from zero
	function automatic longint unsigned unit_mag(longint unsigned mag, longint unsigned s);
		longint unsigned rhs, q, c, t;
		rhs = (mag * 32768) * (mag * 32768);
		q = 0;
		for (int b = 14; b >= 0; b--) begin
			c = q | (64'd1 << b);
			t = 2 * c - 1;
			if (t * t * s <= rhs) q = c;
		end
		return q;
	endfunction

	function automatic vertex_t make_vertex(grid_pt_t p);
		vertex_t r;
		int d, m;
		longint a [3];
		longint unsigned s, q, idx;
		logic [15:0] w [3];
		r = '{default: '0};
		d = eff_density();
		m = d - 1;
		if (p.face > FACE_NZ || p.col >= d || p.row >= d) begin
			r.bad = 1'b1;
			return r;
		end
		s = 0;
		for (int k = 0; k < 3; k++) begin
			a[k] = corner_tbl[p.face][k] * m + 2 * colstep_tbl[p.face][k] * int'(p.col)
				+ 2 * rowstep_tbl[p.face][k] * int'(p.row);
			s += a[k] * a[k];
		end
		for (int k = 0; k < 3; k++) begin
			q = unit_mag(a[k] < 0 ? -a[k] : a[k], s);
			w[k] = a[k] < 0 ? 16'(-q) : 16'(q);
		end
		r.px = w[0];
		r.py = w[1];
		r.pz = w[2];
		r.u = 16'((longint'(p.col) * 65536 + m) / (2 * m));
		r.v = 16'((longint'(p.row) * 65536 + m) / (2 * m));
		idx = longint'(p.face) * d * d + longint'(p.row) * d + p.col;
		r.idx = csv_pkg::IW'(idx);
		if (p.row < m) begin
			r.partner = csv_pkg::IW'(idx + d);
			r.pair_ok = 1'b1;
		end
		return r;
	endfunction

	// driver: bursts with random gaps, no gaps while steady is set
	always @(posedge clk) begin
		grid_pt_t p;
		grid_pt_t acc;
		logic nxt;
		if (start && !busy) begin
			acc.face = cube_face;
			acc.col = grid_col;
			acc.row = grid_row;
			vertex_q.insert(vertex_q.size(), make_vertex(acc));
		end
		nxt = start && busy;
		if (!(start && busy)) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (point_q.size() > 0) begin
				p = point_q.pop_front();
				cube_face <= p.face;
				grid_col <= p.col;
				grid_row <= p.row;
				nxt = 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 20);
					gap_left = steady ? 0 : $urandom_range(0, 6);
				end
			end
		end
		start <= nxt;
	end

	// monitor
	always @(posedge clk) begin
		vertex_t e;
		if (done) begin
			if (vertex_q.size() == 0) begin
				$error("unexpected result transaction");
				failed = 1;
			end else begin
				e = vertex_q.pop_front();
				if (pos_x !== e.px) begin
					$error("pos_x exp %0d got %0d", e.px, pos_x); failed = 1;
				end
				if (pos_y !== e.py) begin
					$error("pos_y exp %0d got %0d", e.py, pos_y); failed = 1;
				end
				if (pos_z !== e.pz) begin
					$error("pos_z exp %0d got %0d", e.pz, pos_z); failed = 1;
				end
				if (tex_u !== e.u) begin
					$error("tex_u exp %0d got %0d", e.u, tex_u); failed = 1;
				end
				if (tex_v !== e.v) begin
					$error("tex_v exp %0d got %0d", e.v, tex_v); failed = 1;
				end
				if (vertex_index !== e.idx) begin
					$error("vertex_index exp %0d got %0d", e.idx, vertex_index); failed = 1;
				end
				if (strip_partner !== e.partner) begin
					$error("strip_partner exp %0d got %0d", e.partner, strip_partner);
					failed = 1;
				end
				if (strip_pair_valid !== e.pair_ok) begin
					$error("strip_pair_valid exp %0d got %0d", e.pair_ok, strip_pair_valid);
					failed = 1;
				end
				if (bad_coordinate !== e.bad) begin
					$error("bad_coordinate exp %0d got %0d", e.bad, bad_coordinate);
					failed = 1;
				end
			end
		end
	end

	task automatic drain();
		do @(negedge clk); while (point_q.size() > 0 || start || vertex_q.size() > 0);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	task automatic set_density(logic [csv_pkg::DW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		density_reg = val;
		cfg_valid <= 1'b0;
	endtask

	task automatic add_random(int n);
		grid_pt_t p;
		int d;
		d = eff_density();
		repeat (n) begin
			p.face = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(FACE_NONE6, FACE_NONE7))
				: 3'($urandom_range(FACE_PX, FACE_NZ));
			p.col = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, d - 1));
			p.row = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, d - 1));
			queue_point(p);
		end
	endtask

	initial begin
		logic [csv_pkg::DW-1:0] settings [9] = '{9'd2, 9'd0, 9'd1, 9'd3, 9'd256, 9'd255,
			9'd511, 9'd257, 9'd100};
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		// corners, edges and out-of-range points at the reset density
		for (int f = FACE_PX; f <= FACE_NONE7; f++) queue_point('{3'(f), 8'd0, 8'd0});
		for (int f = FACE_PX; f <= FACE_NZ; f++) queue_point('{3'(f), 8'd15, 8'd15});
		queue_point('{FACE_PY, 8'd15, 8'd0});
		queue_point('{FACE_NY, 8'd0, 8'd15});
		queue_point('{FACE_PZ, 8'd7, 8'd8});
		queue_point('{FACE_NX, 8'd16, 8'd3});
		queue_point('{FACE_PX, 8'd3, 8'd16});
		queue_point('{FACE_NZ, 8'd255, 8'd255});
		queue_point('{FACE_NONE7, 8'd255, 8'd0});
		add_random(60);
		drain();
		foreach (settings[i]) begin
			steady = (i % 3 == 2);
			set_density(settings[i]);
			add_random(50);
			if (eff_density() == csv_pkg::MAX_DENSITY) begin
				queue_point('{FACE_NZ, 8'd255, 8'd255});
				queue_point('{FACE_PX, 8'd255, 8'd254});
			end
			drain();
		end
		if (!failed) begin
			$display("cube_sphere_vertex_generator test passed");
		end else begin
			$display("cube_sphere_vertex_generator test failed");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("cube_sphere_vertex_generator test failed");
		$finish;
	end

endmodule
